[hw/rtl/lcs_pkg.sv]
package lcs_pkg;

  // Request operation codes.
  typedef enum logic [3:0] {
    OP_ACQUIRE    = 4'd0,
    OP_RELEASE    = 4'd1,
    OP_WAIT       = 4'd2,
    OP_SIGNAL     = 4'd3,
    OP_BROADCAST  = 4'd4,
    OP_CREATE_LK  = 4'd5,
    OP_DESTROY_LK = 4'd6,
    OP_CREATE_CV  = 4'd7,
    OP_DESTROY_CV = 4'd8
  } op_e;

  // Reply status codes.
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_INDEX  = 4'd1,
    ST_DELETED    = 4'd2,
    ST_ALREADY    = 4'd3,
    ST_NOT_OWNER  = 4'd4,
    ST_DEFERRED   = 4'd5,
    ST_TABLE_FULL = 4'd6,
    ST_WRONG_LOCK = 4'd7,
    ST_NONE_WAIT  = 4'd8,
    ST_WAIT_FULL  = 4'd9
  } status_e;

  // Marker for a condition variable that is not bound to a lock.
  localparam logic [8:0] NO_BOUND = 9'h1FF;

  // Classified request passed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [7:0]  ti;
    logic [7:0]  li;
    logic [15:0] who;
    logic        bad;
  } cmd_t;

  // One reply item.
  typedef struct packed {
    logic [7:0] to_machine;
    logic [7:0] to_mailbox;
    status_e    status;
    logic [7:0] value;
    logic       last;
  } rsp_t;

  function automatic rsp_t mk_rsp(logic [15:0] who, status_e st, logic [7:0] val,
                                  logic last);
    rsp_t r;
    r.to_machine = who[15:8];
    r.to_mailbox = who[7:0];
    r.status     = st;
    r.value      = val;
    r.last       = last;
    return r;
  endfunction

endpackage

[hw/rtl/lcs_req_if.sv]
interface lcs_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] op;
  logic [7:0] target_index;
  logic [7:0] lock_index;
  logic [7:0] machine;
  logic [7:0] mailbox;

  modport source (output valid, op, target_index, lock_index, machine, mailbox,
                  input ready);
  modport sink (input valid, op, target_index, lock_index, machine, mailbox,
                output ready);
endinterface

[hw/rtl/lcs_rsp_if.sv]
interface lcs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] to_machine;
  logic [7:0] to_mailbox;
  logic [3:0] status;
  logic [7:0] value;
  logic       last;

  modport source (output valid, to_machine, to_mailbox, status, value, last,
                  input ready);
  modport sink (input valid, to_machine, to_mailbox, status, value, last,
                output ready);
endinterface

[hw/rtl/lcs_front.sv]
module lcs_front #(
  parameter int LOCK_SLOTS = 256,
  parameter int CV_SLOTS   = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcs_req_if.sink       req_i,
  output logic          cmd_valid_o,
  output lcs_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  lcs_pkg::cmd_t cmd;
  logic          lk_bad, cv_bad, known, push;
  lcs_pkg::cmd_t fifo_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  // Range checks against the configured table sizes.
  assign lk_bad = ({24'd0, req_i.target_index} >= LOCK_SLOTS);
  assign cv_bad = ({24'd0, req_i.target_index} >= CV_SLOTS);
  assign known  = (req_i.op <= 4'(lcs_pkg::OP_DESTROY_CV));

  // Classify the request; unknown codes are dropped here.
  always_comb begin
    cmd.op  = lcs_pkg::op_e'(req_i.op);
    cmd.ti  = req_i.target_index;
    cmd.li  = req_i.lock_index;
    cmd.who = {req_i.machine, req_i.mailbox};
    unique case (cmd.op)
      lcs_pkg::OP_ACQUIRE, lcs_pkg::OP_RELEASE, lcs_pkg::OP_DESTROY_LK: begin
        cmd.bad = lk_bad;
      end
      lcs_pkg::OP_WAIT, lcs_pkg::OP_SIGNAL, lcs_pkg::OP_BROADCAST: begin
        cmd.bad = cv_bad || ({24'd0, req_i.lock_index} >= LOCK_SLOTS);
      end
      lcs_pkg::OP_DESTROY_CV: begin
        cmd.bad = cv_bad;
      end
      default: begin
        cmd.bad = 1'b0;
      end
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  // Two-entry queue to the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd;
  end

endmodule

[hw/rtl/lcs_back.sv]
module lcs_back #(
  parameter int LOCK_SLOTS   = 256,
  parameter int CV_SLOTS     = 256,
  parameter int WAITER_SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  lcs_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  lcs_rsp_if.source     rsp_o
);

  localparam int LD  = (LOCK_SLOTS < 256) ? LOCK_SLOTS : 256;
  localparam int CD  = (CV_SLOTS < 256) ? CV_SLOTS : 256;
  localparam int LIW = $clog2(LD);
  localparam int CIW = $clog2(CD);
  localparam int WW  = $clog2(WAITER_SLOTS);
  localparam int CW  = $clog2(WAITER_SLOTS + 1);
  localparam int LMW = $clog2(LD + 1);
  localparam int CMW = $clog2(CD + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EX     = 3'd1;
  localparam logic [2:0] S_HAND   = 3'd2;
  localparam logic [2:0] S_CVPUSH = 3'd3;
  localparam logic [2:0] S_WAKE   = 3'd4;
  localparam logic [2:0] S_WAKE2  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  typedef struct packed {
    logic          taken;
    logic          doomed;
    logic [15:0]   holder;
    logic [WW-1:0] head;
    logic [WW-1:0] tail;
    logic [CW-1:0] len;
  } lrec_t;

  typedef struct packed {
    logic          doomed;
    logic [8:0]    bound;
    logic [WW-1:0] head;
    logic [WW-1:0] tail;
    logic [CW-1:0] len;
  } crec_t;

  logic [2:0]    st_q, st_d;
  logic          after_q, after_d;
  lcs_pkg::cmd_t cur_q, cur_d;
  logic [LIW-1:0] lidx_q, lidx_d;
  logic [CIW-1:0] cidx_q, cidx_d;
  logic [7:0]    lk8_q, lk8_d;
  logic [WW-1:0] w_q, w_d, fh_q, fh_d;
  logic [CW-1:0] fc_q, fc_d;
  logic [LMW-1:0] lmade_q, lmade_d;
  logic [CMW-1:0] cmade_q, cmade_d;
  logic [LD-1:0] llive_q, llive_d;
  logic [CD-1:0] clive_q, clive_d;
  logic [WW-1:0] link_q [WAITER_SLOTS];
  logic [WW-1:0] link_d [WAITER_SLOTS];
  lrec_t         lw_q, lw_d;
  crec_t         cw_q, cw_d;
  logic [15:0]   wc_q;
  lrec_t         lock_mem [LD];
  crec_t         cv_mem [CD];
  logic [15:0]   wmem [WAITER_SLOTS];
  logic          ov_q, ov_d;
  lcs_pkg::rsp_t o_q, o_d;

  logic           lwe, cwe, wwe, out_free, holds;
  logic [LIW-1:0] lwa;
  lrec_t          lwd;
  logic [CIW-1:0] cwa;
  crec_t          cwd;
  logic [WW-1:0]  wwa, wra;

  assign out_free = !ov_q || rsp_o.ready;
  assign holds    = lw_q.taken && (lw_q.holder == cur_q.who);

  // Request sequencer: one memory read, then a few update steps.
  always_comb begin
    logic [WW-1:0] w;
    logic [CW-1:0] nl;
    logic          is_cv;
    st_d     = st_q;
    after_d  = after_q;
    cur_d    = cur_q;
    lidx_d   = lidx_q;
    cidx_d   = cidx_q;
    lk8_d    = lk8_q;
    w_d      = w_q;
    fh_d     = fh_q;
    fc_d     = fc_q;
    lmade_d  = lmade_q;
    cmade_d  = cmade_q;
    llive_d  = llive_q;
    clive_d  = clive_q;
    link_d   = link_q;
    lw_d     = lw_q;
    cw_d     = cw_q;
    lwe      = 1'b0;
    lwa      = lidx_q;
    lwd      = lw_d;
    cwe      = 1'b0;
    cwa      = cidx_q;
    cwd      = cw_d;
    wwe      = 1'b0;
    wwa      = fh_q;
    wra      = w_q;
    cmd_pop_o = 1'b0;
    o_d      = o_q;
    ov_d     = rsp_o.ready ? 1'b0 : ov_q;
    w        = '0;
    nl       = '0;
    is_cv    = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        is_cv = (cmd_i.op == lcs_pkg::OP_WAIT) || (cmd_i.op == lcs_pkg::OP_SIGNAL) ||
                (cmd_i.op == lcs_pkg::OP_BROADCAST);
        lk8_d  = is_cv ? cmd_i.li : cmd_i.ti;
        lidx_d = lk8_d[LIW-1:0];
        cidx_d = cmd_i.ti[CIW-1:0];
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          st_d      = S_EX;
        end
      end

      S_EX: begin
        if (out_free) begin
          st_d = S_IDLE;
          if (cur_q.bad) begin
            o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_BAD_INDEX, 8'd0, 1'b1);
            ov_d = 1'b1;
          end else begin
            unique case (cur_q.op)
              lcs_pkg::OP_ACQUIRE: begin
                ov_d = 1'b1;
                if (!llive_q[lidx_q]) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DELETED, 8'd0, 1'b1);
                end else if (holds) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_ALREADY, 8'd0, 1'b1);
                end else if (!lw_q.taken) begin
                  lw_d.taken = 1'b1;
                  lw_d.holder = cur_q.who;
                  lwe = 1'b1;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, cur_q.ti, 1'b1);
                end else if (fc_q == '0) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_WAIT_FULL, 8'd0, 1'b1);
                end else begin
                  // Blocked: park the client on the lock queue, no reply.
                  ov_d = rsp_o.ready ? 1'b0 : ov_q;
                  w = fh_q;
                  fh_d = link_q[w];
                  fc_d = fc_q - 1'b1;
                  wwe = 1'b1;
                  wwa = w;
                  link_d[w] = '0;
                  if (lw_q.len == '0) lw_d.head = w;
                  else link_d[lw_q.tail] = w;
                  lw_d.tail = w;
                  lw_d.len = lw_q.len + 1'b1;
                  lwe = 1'b1;
                end
              end

              lcs_pkg::OP_RELEASE: begin
                ov_d = 1'b1;
                if (!llive_q[lidx_q]) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DELETED, 8'd0, 1'b1);
                end else if (!holds) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_NOT_OWNER, 8'd0, 1'b1);
                end else begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, cur_q.ti,
                                        lw_q.len == '0);
                  if (lw_q.len == '0) begin
                    lw_d.taken = 1'b0;
                    lwe = 1'b1;
                    if (lw_q.doomed) begin
                      llive_d[lidx_q] = 1'b0;
                      lw_d.doomed = 1'b0;
                    end
                  end else begin
                    w_d = lw_q.head;
                    wra = lw_q.head;
                    lw_d.head = link_q[lw_q.head];
                    lw_d.len = lw_q.len - 1'b1;
                    lwe = 1'b1;
                    after_d = 1'b0;
                    st_d = S_HAND;
                  end
                end
              end

              lcs_pkg::OP_WAIT, lcs_pkg::OP_SIGNAL, lcs_pkg::OP_BROADCAST: begin
                ov_d = 1'b1;
                if (!llive_q[lidx_q] || !clive_q[cidx_q]) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DELETED, 8'd0, 1'b1);
                end else if (!holds) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_NOT_OWNER, 8'd0, 1'b1);
                end else if (cur_q.op == lcs_pkg::OP_WAIT) begin
                  if (cw_q.bound != lcs_pkg::NO_BOUND && cw_q.bound != {1'b0, cur_q.li}) begin
                    o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_WRONG_LOCK, 8'd0, 1'b1);
                  end else if (fc_q == '0) begin
                    o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_WAIT_FULL, 8'd0, 1'b1);
                  end else begin
                    ov_d = rsp_o.ready ? 1'b0 : ov_q;
                    cw_d.bound = {1'b0, cur_q.li};
                    cwe = 1'b1;
                    if (lw_q.len == '0) begin
                      lw_d.taken = 1'b0;
                      lwe = 1'b1;
                      if (lw_q.doomed) begin
                        llive_d[lidx_q] = 1'b0;
                        lw_d.doomed = 1'b0;
                      end
                      st_d = S_CVPUSH;
                    end else begin
                      w_d = lw_q.head;
                      wra = lw_q.head;
                      lw_d.head = link_q[lw_q.head];
                      lw_d.len = lw_q.len - 1'b1;
                      lwe = 1'b1;
                      after_d = 1'b1;
                      st_d = S_HAND;
                    end
                  end
                end else if (cur_q.op == lcs_pkg::OP_SIGNAL) begin
                  if (cw_q.len == '0) begin
                    o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_NONE_WAIT, 8'd0, 1'b1);
                  end else if (cw_q.bound != {1'b0, cur_q.li}) begin
                    o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_WRONG_LOCK, 8'd0, 1'b1);
                  end else begin
                    ov_d = rsp_o.ready ? 1'b0 : ov_q;
                    st_d = S_WAKE;
                  end
                end else begin
                  if (cw_q.len != '0 && cw_q.bound != {1'b0, cur_q.li}) begin
                    o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_WRONG_LOCK, 8'd0, 1'b1);
                  end else if (cw_q.len == '0) begin
                    o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, cur_q.ti, 1'b1);
                  end else begin
                    ov_d = rsp_o.ready ? 1'b0 : ov_q;
                    st_d = S_WAKE;
                  end
                end
              end

              lcs_pkg::OP_CREATE_LK: begin
                ov_d = 1'b1;
                if (lmade_q >= LMW'(LD)) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_TABLE_FULL, 8'd0, 1'b1);
                end else begin
                  llive_d[lmade_q[LIW-1:0]] = 1'b1;
                  lwe = 1'b1;
                  lwa = lmade_q[LIW-1:0];
                  lmade_d = lmade_q + 1'b1;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, 8'(lmade_q), 1'b1);
                end
              end

              lcs_pkg::OP_DESTROY_LK: begin
                ov_d = 1'b1;
                if (!llive_q[lidx_q]) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DELETED, 8'd0, 1'b1);
                end else if (lw_q.taken || lw_q.len != '0) begin
                  lw_d.doomed = 1'b1;
                  lwe = 1'b1;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DEFERRED, cur_q.ti, 1'b1);
                end else begin
                  llive_d[lidx_q] = 1'b0;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, cur_q.ti, 1'b1);
                end
              end

              lcs_pkg::OP_CREATE_CV: begin
                ov_d = 1'b1;
                if (cmade_q >= CMW'(CD)) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_TABLE_FULL, 8'd0, 1'b1);
                end else begin
                  clive_d[cmade_q[CIW-1:0]] = 1'b1;
                  cwe = 1'b1;
                  cwa = cmade_q[CIW-1:0];
                  cmade_d = cmade_q + 1'b1;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, 8'(cmade_q), 1'b1);
                end
              end

              lcs_pkg::OP_DESTROY_CV: begin
                ov_d = 1'b1;
                if (!clive_q[cidx_q]) begin
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DELETED, 8'd0, 1'b1);
                end else if (cw_q.len != '0) begin
                  cw_d.doomed = 1'b1;
                  cwe = 1'b1;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_DEFERRED, cur_q.ti, 1'b1);
                end else begin
                  clive_d[cidx_q] = 1'b0;
                  o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, cur_q.ti, 1'b1);
                end
              end

              default: begin
              end
            endcase
          end
        end
      end

      // Hand the lock to the first waiter and free its waiter entry.
      S_HAND: begin
        if (out_free) begin
          lw_d.holder = wc_q;
          lwe = 1'b1;
          link_d[w_q] = fh_q;
          fh_d = w_q;
          fc_d = fc_q + 1'b1;
          o_d = lcs_pkg::mk_rsp(wc_q, lcs_pkg::ST_OK, lk8_q, 1'b1);
          ov_d = 1'b1;
          st_d = after_q ? S_CVPUSH : S_IDLE;
        end
      end

      // Park the waiting client on the condition queue.
      S_CVPUSH: begin
        w = fh_q;
        fh_d = link_q[w];
        fc_d = fc_q - 1'b1;
        wwe = 1'b1;
        wwa = w;
        link_d[w] = '0;
        if (cw_q.len == '0) cw_d.head = w;
        else link_d[cw_q.tail] = w;
        cw_d.tail = w;
        cw_d.len = cw_q.len + 1'b1;
        cwe = 1'b1;
        st_d = S_IDLE;
      end

      // Pop one condition waiter and fetch its client.
      S_WAKE: begin
        w = cw_q.head;
        w_d = w;
        wra = w;
        nl = cw_q.len - 1'b1;
        cw_d.head = link_q[w];
        cw_d.len = nl;
        if (nl == '0) begin
          cw_d.bound = lcs_pkg::NO_BOUND;
          if (cw_q.doomed) begin
            clive_d[cidx_q] = 1'b0;
            cw_d.doomed = 1'b0;
          end
        end
        cwe = 1'b1;
        st_d = S_WAKE2;
      end

      // Move the woken client to the lock queue, or tell it it owns the lock.
      S_WAKE2: begin
        if (wc_q == cur_q.who) begin
          if (out_free) begin
            o_d = lcs_pkg::mk_rsp(wc_q, lcs_pkg::ST_ALREADY, 8'd0, 1'b0);
            ov_d = 1'b1;
            link_d[w_q] = fh_q;
            fh_d = w_q;
            fc_d = fc_q + 1'b1;
            st_d = (cur_q.op == lcs_pkg::OP_SIGNAL || cw_q.len == '0) ? S_FIN : S_WAKE;
          end
        end else begin
          link_d[w_q] = '0;
          if (lw_q.len == '0) lw_d.head = w_q;
          else link_d[lw_q.tail] = w_q;
          lw_d.tail = w_q;
          lw_d.len = lw_q.len + 1'b1;
          lwe = 1'b1;
          st_d = (cur_q.op == lcs_pkg::OP_SIGNAL || cw_q.len == '0) ? S_FIN : S_WAKE;
        end
      end

      S_FIN: begin
        if (out_free) begin
          o_d = lcs_pkg::mk_rsp(cur_q.who, lcs_pkg::ST_OK, cur_q.ti, 1'b1);
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase

    // Creation writes a cleared record; other writes use the working copy.
    if (st_q == S_EX && cur_q.op == lcs_pkg::OP_CREATE_LK) begin
      lwd = '0;
    end else begin
      lwd = lw_d;
    end
    if (st_q == S_EX && cur_q.op == lcs_pkg::OP_CREATE_CV) begin
      cwd = '{doomed: 1'b0, bound: lcs_pkg::NO_BOUND, head: '0, tail: '0, len: '0};
    end else begin
      cwd = cw_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      fh_q     <= '0;
      fc_q     <= CW'(WAITER_SLOTS);
      lmade_q  <= '0;
      cmade_q  <= '0;
      llive_q  <= '0;
      clive_q  <= '0;
      ov_q     <= 1'b0;
      for (int i = 0; i < WAITER_SLOTS; i++) begin
        link_q[i] <= (i == WAITER_SLOTS - 1) ? '0 : WW'(i + 1);
      end
    end else begin
      st_q     <= st_d;
      fh_q     <= fh_d;
      fc_q     <= fc_d;
      lmade_q  <= lmade_d;
      cmade_q  <= cmade_d;
      llive_q  <= llive_d;
      clive_q  <= clive_d;
      ov_q     <= ov_d;
      link_q   <= link_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    after_q <= after_d;
    cur_q   <= cur_d;
    lidx_q  <= lidx_d;
    cidx_q  <= cidx_d;
    lk8_q   <= lk8_d;
    w_q     <= w_d;
    o_q     <= o_d;
  end

  // Record memories: registered read into the working copy, single write port.
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE) begin
      lw_q <= lock_mem[lidx_d];
      cw_q <= cv_mem[cidx_d];
    end else begin
      lw_q <= lw_d;
      cw_q <= cw_d;
    end
    if (lwe) lock_mem[lwa] <= lwd;
    if (cwe) cv_mem[cwa] <= cwd;
  end

  // Waiter client store.
  always_ff @(posedge clk_i) begin
    wc_q <= wmem[wra];
    if (wwe) wmem[wwa] <= cur_q.who;
  end

  assign rsp_o.valid      = ov_q;
  assign rsp_o.to_machine = o_q.to_machine;
  assign rsp_o.to_mailbox = o_q.to_mailbox;
  assign rsp_o.status     = o_q.status;
  assign rsp_o.value      = o_q.value;
  assign rsp_o.last       = o_q.last;

  // The free count never exceeds the waiter store size.
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(WAITER_SLOTS)) else $error("free count overflow");

  // Parking a waiter on a condition queue always finds a free entry.
  a_cvpush_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_CVPUSH |-> fc_q != '0) else $error("no free waiter entry");

  // A wake step only runs on a nonempty condition queue.
  a_wake_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_WAKE |-> cw_q.len != '0) else $error("wake on empty queue");

endmodule

[hw/rtl/lock_and_condition_server_top.sv]
// Lock and condition-variable server.
// Requests enter on req_i (valid/ready); each names an operation, an object
// index, a paired lock index and the client (machine, mailbox). Replies leave
// on rsp_o (valid/ready) addressed to a client; the final reply caused by a
// request has last set, and a request may cause no reply (a blocked acquire,
// a successful wait, an unknown operation code).
// Timing: the front queue holds two requests. The back end first reads the
// lock and condition records and then decides. A release or wait that hands
// the lock on adds a hand-over step, and a wait adds a parking step; signal
// wakes one waiter and broadcast every waiter (none on an empty queue), each
// wake taking a pop and a move step before the final reply, as set by the
// single-port record memories and the waiter store.
// Replies sit in one output register; while the receiver holds ready low the
// back end stalls at its next reply and the front keeps accepting until its
// queue is full.
// Reset empties all tables, threads every waiter entry onto the free list and
// takes effect at once; no clearing pass is needed.
module lock_and_condition_server_top #(
  parameter int LOCK_SLOTS   = 256,
  parameter int CV_SLOTS     = 256,
  parameter int WAITER_SLOTS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcs_req_if.sink   req_i,
  lcs_rsp_if.source rsp_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  lcs_pkg::cmd_t cmd;

  // Accept and classify.
  lcs_front #(
    .LOCK_SLOTS(LOCK_SLOTS),
    .CV_SLOTS  (CV_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  // Execute against the tables.
  lcs_back #(
    .LOCK_SLOTS  (LOCK_SLOTS),
    .CV_SLOTS    (CV_SLOTS),
    .WAITER_SLOTS(WAITER_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .rsp_o      (rsp_o)
  );

endmodule
